/* rtl/bpe_token_encoder_top_defines.svh */
// Assertion macros shared by the encoder RTL files.
`ifndef BPE_TOKEN_ENCODER_TOP_DEFINES_SVH
`define BPE_TOKEN_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bpe_pkg.sv */
// Shared types and constants for the BPE token encoder.
package bpe_pkg;

	localparam int MAX_MERGES_DEFAULT = 32;
	localparam int BASE_IDS           = 256;
	localparam int TOKEN_W            = 9;
	localparam int BYTE_W             = 8;
	localparam int RULE_IDX_W         = 5;
	localparam int RULE_SLOTS         = 1 << RULE_IDX_W;
	localparam int CFG_W              = 6;
	localparam int IN_TDATA_W         = 32;
	localparam int OUT_TDATA_W        = 16;

	typedef logic [TOKEN_W-1:0]    token_t;
	typedef logic [RULE_IDX_W-1:0] rule_idx_t;
	typedef logic [CFG_W-1:0]      cfg_t;

	// Input item kinds carried on s_tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	// Messages that travel down the cell chain
	typedef enum logic [1:0] {
		MSG_TOKEN,
		MSG_STEP,
		MSG_FLUSH,
		MSG_LOAD
	} msg_kind_t;

	typedef struct packed {
		msg_kind_t kind;
		rule_idx_t idx;
		token_t    tok;
		token_t    right;
	} msg_t;

endpackage

/* rtl/bpe_cell.sv */
// One merge stage of the encoder chain with a two-entry output queue.
`include "bpe_token_encoder_top_defines.svh"

module bpe_cell #(
	parameter int CellId = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bpe_pkg::cfg_t active_merges,
	input  logic          in_valid,
	output logic          in_ready,
	input  bpe_pkg::msg_t in_msg,
	output logic          out_valid,
	input  logic          out_ready,
	output bpe_pkg::msg_t out_msg
);

	localparam bpe_pkg::token_t MergeTok = bpe_pkg::token_t'(bpe_pkg::BASE_IDS + CellId);

	bpe_pkg::token_t rule_left_q;
	bpe_pkg::token_t rule_right_q;
	bpe_pkg::token_t held_q;
	logic            held_v_q;
	bpe_pkg::msg_t   slot0_q;
	bpe_pkg::msg_t   slot1_q;
	logic [1:0]      count_q;

	logic          space;
	logic          cell_active;
	logic          idx_hit;
	logic          match;
	logic          flush_held;
	logic          emit;
	bpe_pkg::msg_t emit_msg;
	logic          held_set;
	logic          held_clr;
	logic          rule_wr;
	logic          pop;

	assign space       = (count_q != 2'd2);
	assign cell_active = (active_merges > bpe_pkg::cfg_t'(CellId));
	assign idx_hit     = (CellId < bpe_pkg::RULE_SLOTS) &&
		(in_msg.idx == bpe_pkg::rule_idx_t'(CellId));
	assign match       = (held_q == rule_left_q) && (in_msg.tok == rule_right_q);

	// Release the held token first on a flush, or on any text traffic while out of force
	assign flush_held = held_v_q && (in_msg.kind != bpe_pkg::MSG_LOAD) &&
		(!cell_active || (in_msg.kind == bpe_pkg::MSG_FLUSH));

	assign in_ready = space && !flush_held;

	// Decide what this request produces
	always_comb begin
		emit     = 1'b0;
		emit_msg = in_msg;
		held_set = 1'b0;
		held_clr = 1'b0;
		rule_wr  = 1'b0;
		if (in_valid && space) begin
			if (flush_held) begin
				emit          = 1'b1;
				emit_msg.kind = bpe_pkg::MSG_TOKEN;
				emit_msg.tok  = held_q;
				held_clr      = 1'b1;
			end else begin
				case (in_msg.kind)
					bpe_pkg::MSG_LOAD: begin
						emit    = 1'b1;
						rule_wr = idx_hit;
					end
					bpe_pkg::MSG_TOKEN: begin
						if (!cell_active) begin
							emit = 1'b1;
						end else if (!held_v_q) begin
							held_set = 1'b1;
						end else if (match) begin
							emit         = 1'b1;
							emit_msg.tok = MergeTok;
							held_clr     = 1'b1;
						end else begin
							emit         = 1'b1;
							emit_msg.tok = held_q;
							held_set     = 1'b1;
						end
					end
					default: begin
						emit = 1'b1;
					end
				endcase
			end
		end
	end

	assign pop       = (count_q != 2'd0) && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_msg   = slot0_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			held_v_q <= 1'b0;
		end else begin
			count_q <= count_q + {1'b0, emit} - {1'b0, pop};
			if (held_clr) begin
				held_v_q <= 1'b0;
			end else if (held_set) begin
				held_v_q <= 1'b1;
			end
		end
	end

	// Queue, held token and rule payload
	always_ff @(posedge clk) begin
		if (emit && ((count_q == 2'd0) || ((count_q == 2'd1) && pop))) begin
			slot0_q <= emit_msg;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
		if (emit && (count_q == 2'd1) && !pop) begin
			slot1_q <= emit_msg;
		end
		if (held_set) begin
			held_q <= in_msg.tok;
		end
		if (rule_wr) begin
			rule_left_q  <= in_msg.tok;
			rule_right_q <= in_msg.right;
		end
	end

	`BPE_ASSERT_NEXT(a_flush_empties_cell, in_valid && in_ready && in_msg.kind == bpe_pkg::MSG_FLUSH, !held_v_q, "cell still holds a token after passing a flush")
	`BPE_ASSERT_NEXT(a_idle_cell_holds_nothing, in_valid && in_ready && !cell_active && in_msg.kind != bpe_pkg::MSG_LOAD, !held_v_q, "stage out of force captured a token")

endmodule

/* rtl/bpe_token_encoder_top.sv */
// Byte-level BPE encoder: input adapter, chain of merge cells, output tagging.
// Load items (s_tuser = 0) write one merge rule and enter the chain without a marker. A
// text byte (s_tuser = 1) enters the first cell as a token followed by a step marker, so
// the input cannot take a new byte until the marker has entered the chain; both messages
// use the one request slot of the first cell. The tail holds a token back until the next
// message behind it arrives. A byte with s_tlast set flushes every held token, and each
// cell that holds one sends it on ahead of the flush marker. The last token of the text
// is tagged with m_tlast. The merge rule count is written on the cfg port, which is
// always ready; write it only while the chain is empty.
`include "bpe_token_encoder_top_defines.svh"

module bpe_token_encoder_top #(
	parameter int MAX_MERGES = bpe_pkg::MAX_MERGES_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// cfg_data: active_merges
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bpe_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: rule_index[4:0], left_id[13:5], right_id[22:14], text_byte[30:23], zero[31]
	input  logic [bpe_pkg::IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: op
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: token_id[8:0], zero[15:9]
	output logic [bpe_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);

	bpe_pkg::cfg_t        active_q;
	logic                 pend_v_q;
	bpe_pkg::msg_kind_t   pend_kind_q;
	bpe_pkg::token_t      look_q;
	logic                 look_v_q;
	logic                 m_tvalid_q;
	bpe_pkg::token_t      m_tok_q;
	logic                 m_last_q;

	logic [MAX_MERGES:0]  link_valid;
	logic [MAX_MERGES:0]  link_ready;
	bpe_pkg::msg_t        link_msg [MAX_MERGES+1];
	bpe_pkg::msg_t        new_msg;
	bpe_pkg::msg_t        marker_msg;

	logic                 s_take;
	logic                 out_free;
	logic                 tail_ready;
	logic                 tail_take;
	logic                 look_load;
	logic                 look_clr;
	logic                 out_load;
	logic                 out_last;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Unpack the input request into a chain message
	always_comb begin
		new_msg.idx   = s_tdata[4:0];
		new_msg.right = s_tdata[22:14];
		if (s_tuser == bpe_pkg::OP_TEXT) begin
			new_msg.kind = bpe_pkg::MSG_TOKEN;
			new_msg.tok  = bpe_pkg::token_t'(s_tdata[30:23]);
		end else begin
			new_msg.kind = bpe_pkg::MSG_LOAD;
			new_msg.tok  = s_tdata[13:5];
		end
	end

	always_comb begin
		marker_msg      = new_msg;
		marker_msg.kind = pend_kind_q;
	end

	// Feed the byte token, then its step or flush marker
	assign s_tready      = !pend_v_q && link_ready[0];
	assign s_take        = s_tvalid && s_tready;
	assign link_valid[0] = pend_v_q || s_tvalid;
	assign link_msg[0]   = pend_v_q ? marker_msg : new_msg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (s_take && (s_tuser == bpe_pkg::OP_TEXT)) begin
			pend_v_q <= 1'b1;
		end else if (pend_v_q && link_ready[0]) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			pend_kind_q <= s_tlast ? bpe_pkg::MSG_FLUSH : bpe_pkg::MSG_STEP;
		end
	end

	// Chain of merge stages in priority order
	for (genvar i = 0; i < MAX_MERGES; i++) begin : g_cell
		bpe_cell #(
			.CellId(i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.active_merges(active_q),
			.in_valid     (link_valid[i]),
			.in_ready     (link_ready[i]),
			.in_msg       (link_msg[i]),
			.out_valid    (link_valid[i+1]),
			.out_ready    (link_ready[i+1]),
			.out_msg      (link_msg[i+1])
		);
	end

	// Hold one token back until the next message tells whether it ends the text
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		tail_ready = 1'b0;
		look_load  = 1'b0;
		look_clr   = 1'b0;
		out_load   = 1'b0;
		out_last   = 1'b0;
		case (link_msg[MAX_MERGES].kind)
			bpe_pkg::MSG_LOAD: begin
				tail_ready = 1'b1;
			end
			bpe_pkg::MSG_TOKEN: begin
				if (!look_v_q) begin
					tail_ready = 1'b1;
					look_load  = 1'b1;
				end else if (out_free) begin
					tail_ready = 1'b1;
					look_load  = 1'b1;
					out_load   = 1'b1;
				end
			end
			default: begin
				if (!look_v_q) begin
					tail_ready = 1'b1;
				end else if (out_free) begin
					tail_ready = 1'b1;
					look_clr   = 1'b1;
					out_load   = 1'b1;
					out_last   = (link_msg[MAX_MERGES].kind == bpe_pkg::MSG_FLUSH);
				end
			end
		endcase
	end

	assign link_ready[MAX_MERGES] = tail_ready;
	assign tail_take = link_valid[MAX_MERGES] && link_ready[MAX_MERGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (tail_take && look_load) begin
				look_v_q <= 1'b1;
			end else if (tail_take && look_clr) begin
				look_v_q <= 1'b0;
			end
			if (tail_take && out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_take && look_load) begin
			look_q <= link_msg[MAX_MERGES].tok;
		end
		if (tail_take && out_load) begin
			m_tok_q  <= look_q;
			m_last_q <= out_last;
		end
	end

	// Result port
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(bpe_pkg::OUT_TDATA_W - bpe_pkg::TOKEN_W){1'b0}}, m_tok_q};
	assign m_tlast  = m_last_q;

	`BPE_ASSERT_NEXT(a_marker_follows_byte, s_take && s_tuser == bpe_pkg::OP_TEXT,
		pend_v_q, "text byte not followed by a marker")
	`BPE_ASSERT_NEXT(a_final_empties_lookahead, tail_take && out_load && out_last,
		!look_v_q, "token held back after the final token")

endmodule
